### src/particle_motion_step_macros.svh
// Assertion macros for the particle motion step block.
// Used by the checker file only.
`ifndef PARTICLE_MOTION_STEP_MACROS_SVH
`define PARTICLE_MOTION_STEP_MACROS_SVH
// implication checked on every clock edge outside reset
`define PMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pms check failed");
// next-cycle implication
`define PMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pms check failed");
`endif

### src/pms_pkg.sv
// Package for the particle motion step block.
// Widths, register indexes and register reset values.
package pms_pkg;
	localparam int PosW = 32;
	localparam int VelW = 20;
	localparam int LifeW = 24;
	localparam int LimW = 19;
	localparam int GainW = 16;
	localparam int StartLifeW = 22;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 22;

	localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DRAG_GAIN = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MOTION_GAIN = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_START_LIFE = 2'd3;

	localparam logic [LimW-1:0] SpeedLimitRst = 19'd384000;
	localparam logic [GainW-1:0] DragGainRst = 16'd256;
	localparam logic [GainW-1:0] MotionGainRst = 16'd256;
	localparam logic [StartLifeW-1:0] StartLifeRst = 22'd1310720;
endpackage

### src/particle_motion_step.sv
// Particle motion step: one particle moved by speed clamp, drag and Euler step.
// A start word or a tick on a dead particle takes only the final speed root; a tick on a
// live particle first takes the squares, the compare with the squared limit and the four
// drag and motion terms of two products each, and a clamped tick also the root and two
// divides between compare and terms. Roots and divides use the shared one-bit-per-cycle
// root/divide unit pms_iter in turn. A new word is taken only after out_ready takes the result.
// Depends on pms_pkg and pms_iter.
module particle_motion_step import pms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgDataW-1:0]    cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [15:0]            time_step,
	input  logic signed [PosW-1:0] start_x,
	input  logic signed [PosW-1:0] start_y,
	input  logic signed [VelW-1:0] start_vx,
	input  logic signed [VelW-1:0] start_vy,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [PosW-1:0] pos_x,
	output logic signed [PosW-1:0] pos_y,
	output logic signed [PosW-1:0] prev_x,
	output logic signed [PosW-1:0] prev_y,
	output logic signed [VelW-1:0] vel_x,
	output logic signed [VelW-1:0] vel_y,
	output logic [VelW-1:0]        speed,
	output logic                   alive
);
	localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_CMP = 4'd2, S_ROOT = 4'd3,
		S_DIVX = 4'd4, S_DIVY = 4'd5, S_MUL = 4'd6, S_APPLY = 4'd7, S_SPD = 4'd8,
		S_WAIT = 4'd9, S_OUT = 4'd10;

	logic [3:0] st_q;
	logic [2:0] ph_q;
	logic [LimW-1:0] lim_q;
	logic [GainW-1:0] drag_q, mot_q;
	logic [StartLifeW-1:0] life0_q;
	logic signed [PosW-1:0] px_q, py_q, lx_q, ly_q;
	logic signed [VelW-1:0] vx_q, vy_q;
	logic signed [LifeW-1:0] life_q;
	logic in_use_q;
	logic [15:0] dt_q;
	logic [41:0] acc_q;
	logic [39:0] m_q;
	logic [63:0] prod_q;
	logic [VelW-1:0] spd_q;

	logic [20:0] mul_a;
	logic [31:0] mul_b;
	logic [52:0] mul_p;
	logic it_start, it_div, it_busy;
	logic [41:0] it_a;
	logic [20:0] it_d;
	logic [39:0] it_res;
	logic [VelW-1:0] ux, uy;

	assign ux = vx_q[VelW-1] ? VelW'(-vx_q) : vx_q;
	assign uy = vy_q[VelW-1] ? VelW'(-vy_q) : vy_q;
	assign mul_p = {32'd0, mul_a} * {21'd0, mul_b};

	pms_iter u_iter (.clk(clk), .arst_n(arst_n), .start(it_start), .op_div(it_div),
		.a(it_a), .d(it_d), .busy(it_busy), .res(it_res));

	// operand selection for multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_SQ, S_SPD: begin
				mul_a = ph_q[0] ? {1'b0, uy} : {1'b0, ux};
				mul_b = ph_q[0] ? {12'd0, uy} : {12'd0, ux};
			end
			S_CMP: begin
				mul_a = {2'b0, lim_q};
				mul_b = {13'd0, lim_q};
			end
			S_DIVX, S_DIVY: begin
				mul_a = {1'b0, (st_q == S_DIVX) ? ux : uy};
				mul_b = {13'd0, lim_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		it_start = 1'b0;
		it_div = 1'b0;
		it_a = acc_q;
		it_d = 21'(m_q);
		if (st_q == S_CMP && ph_q == 3'd0 && acc_q > 42'(mul_p))
			it_start = 1'b1;
		if (st_q == S_SPD && ph_q == 3'd2)
			it_start = 1'b1;
		if ((st_q == S_DIVX || st_q == S_DIVY) && ph_q == 3'd0) begin
			it_start = 1'b1;
			it_div = 1'b1;
			it_a = 42'(mul_p);
		end
	end

	// drag/motion term = trunc(|v|*g*dt >> 24), computed as (|v|*g)*dt in two products
	logic [VelW-1:0] mag_sel;
	logic [GainW-1:0] gain_sel;
	logic [56:0] tprod;
	logic [36:0] p1;
	always_comb begin
		p1 = 37'(mag_sel) * 37'(gain_sel);
		tprod = 57'(prod_q[36:0]) * 57'(dt_q);
	end

	logic [2:0] mp_q;
	logic signed [PosW+1:0] dv;
	logic signed [PosW+1:0] pn;
	logic [32:0] term;
	logic signed [VelW-1:0] vsel, vsat;
	logic signed [PosW-1:0] psel, psat;
	assign term = 33'(prod_q[56:24]);

	always_comb begin
		vsel = mp_q[0] ? vy_q : vx_q;
		psel = mp_q[0] ? py_q : px_q;
		dv = vsel[VelW-1] ? {{14{vsel[VelW-1]}}, vsel} + {1'b0, term}
			: {{14{vsel[VelW-1]}}, vsel} - {1'b0, term};
		pn = vsel[VelW-1] ? {{2{psel[PosW-1]}}, psel} - {1'b0, term}
			: {{2{psel[PosW-1]}}, psel} + {1'b0, term};
		if (dv > 34'sh7FFFF) vsat = 20'sh7FFFF;
		else if (dv < -34'sh80000) vsat = 20'sh80000;
		else vsat = dv[VelW-1:0];
		if (pn > 34'sh7FFFFFFF) psat = 32'sh7FFFFFFF;
		else if (pn < -34'sh80000000) psat = 32'sh80000000;
		else psat = pn[PosW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph_q <= '0;
			lim_q <= SpeedLimitRst;
			drag_q <= DragGainRst;
			mot_q <= MotionGainRst;
			life0_q <= StartLifeRst;
			px_q <= '0; py_q <= '0; lx_q <= '0; ly_q <= '0;
			vx_q <= '0; vy_q <= '0; life_q <= '0; in_use_q <= 1'b0;
			mp_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED_LIMIT: lim_q <= cfg_data[LimW-1:0];
					REG_DRAG_GAIN: drag_q <= cfg_data[GainW-1:0];
					REG_MOTION_GAIN: mot_q <= cfg_data[GainW-1:0];
					REG_START_LIFE: life0_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (in_valid) begin
					dt_q <= time_step;
					ph_q <= '0;
					if (kind) begin
						px_q <= start_x; py_q <= start_y;
						vx_q <= start_vx; vy_q <= start_vy;
						life_q <= LifeW'(life0_q);
						in_use_q <= 1'b1;
						st_q <= S_SPD;
					end else if (in_use_q) begin
						st_q <= S_SQ;
					end else begin
						st_q <= S_SPD;
					end
				end
				S_SQ: begin
					if (ph_q == 3'd0) begin
						acc_q <= 42'(mul_p);
						ph_q <= 3'd1;
					end else begin
						acc_q <= acc_q + 42'(mul_p);
						ph_q <= '0;
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (ph_q == 3'd0) begin
						if (it_start) ph_q <= 3'd1;
						else begin st_q <= S_MUL; mp_q <= '0; end
					end else if (!it_busy) begin
						m_q <= it_res;
						ph_q <= '0;
						st_q <= S_DIVX;
					end
				end
				S_DIVX, S_DIVY: begin
					if (ph_q == 3'd0) ph_q <= 3'd1;
					else if (!it_busy) begin
						ph_q <= '0;
						if (st_q == S_DIVX) begin
							vx_q <= vx_q[VelW-1] ? -VelW'(it_res) : VelW'(it_res);
							st_q <= S_DIVY;
						end else begin
							vy_q <= vy_q[VelW-1] ? -VelW'(it_res) : VelW'(it_res);
							st_q <= S_MUL;
							mp_q <= '0;
						end
					end
				end
				S_MUL: begin
					// mp: 0 x drag, 1 y drag, 2 x motion, 3 y motion; ph 0 gain product, 1 dt product
					if (ph_q == 3'd0) begin
						prod_q <= 64'(p1);
						ph_q <= 3'd1;
					end else begin
						prod_q <= 64'(tprod);
						ph_q <= '0;
						st_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					case (mp_q)
						3'd0: begin
							vx_q <= vsat;
							mp_q <= 3'd1;
							st_q <= S_MUL;
						end
						3'd1: begin
							vy_q <= vsat;
							mp_q <= 3'd2;
							st_q <= S_MUL;
						end
						3'd2: begin
							lx_q <= px_q;
							px_q <= psat;
							mp_q <= 3'd3;
							st_q <= S_MUL;
						end
						default: begin
							ly_q <= py_q;
							py_q <= psat;
							if (life_q <= 0) in_use_q <= 1'b0;
							else life_q <= life_q - LifeW'(dt_q);
							ph_q <= '0;
							st_q <= S_SPD;
						end
					endcase
				end
				S_SPD: begin
					if (ph_q == 3'd0) begin
						acc_q <= 42'(mul_p);
						ph_q <= 3'd1;
					end else if (ph_q == 3'd1) begin
						acc_q <= acc_q + 42'(mul_p);
						ph_q <= 3'd2;
					end else begin
						ph_q <= '0;
						st_q <= S_WAIT;
					end
				end
				S_WAIT: if (!it_busy) begin
					spd_q <= VelW'(it_res);
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		mag_sel = mp_q[0] ? uy : ux;
		gain_sel = mp_q[1] ? mot_q : drag_q;
	end

	assign in_ready = st_q == S_IDLE;
	assign out_valid = st_q == S_OUT;
	assign pos_x = px_q;
	assign pos_y = py_q;
	assign prev_x = lx_q;
	assign prev_y = ly_q;
	assign vel_x = vx_q;
	assign vel_y = vy_q;
	assign speed = spd_q;
	assign alive = in_use_q;
endmodule

### src/pms_iter.sv
// Shared multi-cycle unit: 42-bit integer square root or 40/21 unsigned divide.
// One result bit per cycle. Depends on pms_pkg.
module pms_iter import pms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        op_div,
	input  logic [41:0] a,
	input  logic [20:0] d,
	output logic        busy,
	output logic [39:0] res
);
	logic [5:0]  cnt_q;
	logic        div_q;
	logic [41:0] rem_q;
	logic [41:0] num_q;
	logic [39:0] root_q;
	logic [20:0] d_q;
	logic [43:0] trial;
	logic [43:0] rem_sh;
	logic [42:0] dsh;

	assign rem_sh = div_q ? {1'b0, rem_q, num_q[41]} : {rem_q, num_q[41:40]};
	assign trial = div_q ? {23'd0, d_q} : {2'b0, root_q[39:0], 2'b01};
	assign dsh = 43'd0;
	assign busy = cnt_q != 6'd0;
	assign res = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			div_q <= 1'b0;
		end else if (start) begin
			cnt_q <= op_div ? 6'd40 : 6'd21;
			div_q <= op_div;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= op_div ? {a[39:0], 2'b00} : a;
			root_q <= '0;
			d_q <= d;
		end else if (busy) begin
			num_q <= div_q ? {num_q[40:0], 1'b0} : {num_q[39:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= 42'(rem_sh - trial);
				root_q <= {root_q[38:0], 1'b1};
			end else begin
				rem_q <= rem_sh[41:0] | 42'(dsh);
				root_q <= {root_q[38:0], 1'b0};
			end
		end
	end
endmodule

### src/pms_checker.sv
// Port-level checker for particle_motion_step, bound to the top level.
// Depends on pms_pkg and particle_motion_step_macros.svh.
`include "particle_motion_step_macros.svh"
module pms_checker import pms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic alive,
	input logic [VelW-1:0] speed
);
	`PMS_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	`PMS_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`PMS_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(speed))
	`PMS_ASSERT_NXT(a_alive, clk, arst_n, !out_valid && !in_ready, $stable(alive) || !in_ready)
endmodule

bind particle_motion_step pms_checker u_pms_checker (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .alive(alive), .speed(speed));
